// File: src/vtd_pkg.sv
// ----------------------------------------------------------------------------
// vtd_pkg: shared definitions for the view topology detector
// register indexes, mode codes, reset values and inter-stage structs
// ----------------------------------------------------------------------------
package vtd_pkg;

    localparam int HISTORY_DEPTH_DEF = 8;
    localparam int POSITION_BITS_DEF = 24;

    localparam int COUNT_W      = 32;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [15:0]       SWING_RESET  = 16'd1024;
    localparam logic [7:0]        STALE_RESET  = 8'd3;
    localparam logic [3:0]        VOTE_RESET   = 4'd6;
    localparam logic signed [2:0] METHOD_RESET = -3'sd1;
    localparam logic signed [2:0] METHOD_MONO  = 3'sd3;
    localparam logic              SHARED_RESET = 1'b0;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SWING  = 3'd0,
        REG_STALE  = 3'd1,
        REG_VOTE   = 3'd2,
        REG_METHOD = 3'd3,
        REG_SHARED = 3'd4
    } vtd_reg_t;

    typedef enum logic [1:0] {
        MODE_UNKNOWN     = 2'd0,
        MODE_STEREO      = 2'd1,
        MODE_ALTERNATING = 2'd2,
        MODE_MONO        = 2'd3
    } vtd_mode_t;

    // settings used by the vote stage
    typedef struct packed {
        logic [15:0]       swing;
        logic [3:0]        vote_thr;
        logic signed [2:0] method;
        logic              shared;
    } vtd_cfg_t;

    // per-request control from the difference stage to the vote stage
    typedef struct packed {
        logic clr;       // two views fell to one: clear ring first
        logic fresh;     // other slot heard recently
        logic shift;     // a second difference exists, push a verdict
        logic have_psd;  // a previous second difference exists
    } vtd_ctrl_t;

endpackage

// File: src/vtd_diff.sv
// ----------------------------------------------------------------------------
// vtd_diff: slot tracking and second-difference stage
// keeps per-slot history, judges freshness, registers the second difference
// ----------------------------------------------------------------------------
module vtd_diff
    import vtd_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load_en,
    input  logic [7:0]                      stale_limit,
    input  logic                            eye_index,
    input  logic signed [POSITION_BITS-1:0] pos [3],
    output logic signed [POSITION_BITS+1:0] accel [3],
    output logic signed [POSITION_BITS+1:0] prev_accel [3],
    output vtd_ctrl_t                       ctrl,
    output logic [COUNT_W-1:0]              count
);

    localparam int DW = POSITION_BITS + 1;
    localparam int AW = POSITION_BITS + 2;

    logic [COUNT_W-1:0]          call_cnt_reg;
    logic [COUNT_W-1:0]          last_call_reg [2];
    logic [1:0]                  seen_reg;
    logic signed [POSITION_BITS-1:0] last_pos_reg [2][3];
    logic                        two_view_reg;
    logic signed [DW-1:0]        pdelta_reg [3];
    logic                        pdv_reg;
    logic signed [AW-1:0]        psd_reg [3];
    logic                        psv_reg;

    logic signed [AW-1:0]        accel_reg [3];
    logic signed [AW-1:0]        prev_accel_reg [3];
    vtd_ctrl_t                   ctrl_reg;
    logic [COUNT_W-1:0]          count_reg;

    logic                        other;
    logic [COUNT_W-1:0]          cnt_next;
    logic [COUNT_W-1:0]          age;
    logic                        fresh;
    logic                        clr;
    logic                        pdv_eff;
    logic                        psv_eff;
    logic                        has_prev;
    logic                        shift;
    logic signed [DW-1:0]        delta [3];
    logic signed [AW-1:0]        acc [3];

    always_comb
    begin
        other    = ~eye_index;
        cnt_next = call_cnt_reg + COUNT_W'(1);
        age      = cnt_next - last_call_reg[other];
        fresh    = seen_reg[other] && (age <= COUNT_W'(stale_limit));
        clr      = two_view_reg && !fresh;
        pdv_eff  = pdv_reg && !clr;
        psv_eff  = psv_reg && !clr;
        has_prev = seen_reg[eye_index];
        shift    = has_prev && pdv_eff;
        for (int k = 0; k < 3; k++)
        begin
            delta[k] = DW'(pos[k]) - DW'(last_pos_reg[eye_index][k]);
            acc[k]   = AW'(delta[k]) - AW'(pdelta_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            call_cnt_reg <= '0;
            seen_reg     <= '0;
            two_view_reg <= 1'b0;
            pdv_reg      <= 1'b0;
            psv_reg      <= 1'b0;
            ctrl_reg     <= '0;
        end
        else if (load_en)
        begin
            call_cnt_reg        <= cnt_next;
            seen_reg[eye_index] <= 1'b1;
            two_view_reg        <= fresh;
            pdv_reg             <= has_prev ? 1'b1 : pdv_eff;
            psv_reg             <= shift ? 1'b1 : psv_eff;
            ctrl_reg.clr        <= clr;
            ctrl_reg.fresh      <= fresh;
            ctrl_reg.shift      <= shift;
            ctrl_reg.have_psd   <= psv_eff;
        end
    end

    // history payload, only read behind the seen and valid flags
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            last_call_reg[eye_index] <= cnt_next;
            count_reg                <= cnt_next;
            for (int k = 0; k < 3; k++)
            begin
                last_pos_reg[eye_index][k] <= pos[k];
                if (has_prev)
                    pdelta_reg[k] <= delta[k];
                if (shift)
                    psd_reg[k] <= acc[k];
                accel_reg[k]      <= acc[k];
                prev_accel_reg[k] <= psd_reg[k];
            end
        end
    end

    assign accel      = accel_reg;
    assign prev_accel = prev_accel_reg;
    assign ctrl       = ctrl_reg;
    assign count      = count_reg;

endmodule

// File: src/vtd_vote.sv
// ----------------------------------------------------------------------------
// vtd_vote: swing test, vote ring and result register
// squares and dot product in parallel, then ring update and mode decision
// ----------------------------------------------------------------------------
module vtd_vote
    import vtd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step_en,
    input  vtd_cfg_t                        cfg,
    input  vtd_ctrl_t                       ctrl,
    input  logic signed [POSITION_BITS+1:0] accel [3],
    input  logic signed [POSITION_BITS+1:0] prev_accel [3],
    input  logic [COUNT_W-1:0]              count,
    output logic [1:0]                      mode,
    output logic [COUNT_W-1:0]              sample_count,
    output logic                            is_mono
);

    localparam int AW    = POSITION_BITS + 2;
    localparam int ProdW = 2 * AW;
    localparam int SumW  = (ProdW + 2 > 34) ? ProdW + 2 : 34;
    localparam int FillW = $clog2(HISTORY_DEPTH + 1);
    localparam int CmpW  = (FillW > 4) ? FillW : 4;

    logic [HISTORY_DEPTH-1:0] ring_reg;
    logic [FillW-1:0]         fill_reg;
    vtd_mode_t                mode_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic                     is_mono_reg;

    logic signed [ProdW-1:0]  sq [3];
    logic signed [ProdW-1:0]  pr [3];
    logic signed [SumW-1:0]   len2;
    logic signed [SumW-1:0]   dot;
    logic signed [SumW-1:0]   lim;
    logic                     flag;
    logic [HISTORY_DEPTH-1:0] ring_base;
    logic [HISTORY_DEPTH-1:0] ring_next;
    logic [FillW-1:0]         fill_base;
    logic [FillW-1:0]         fill_next;
    logic [CmpW-1:0]          ones;
    vtd_mode_t                mode_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq[k] = ProdW'(accel[k]) * ProdW'(accel[k]);
            pr[k] = ProdW'(accel[k]) * ProdW'(prev_accel[k]);
        end
        len2 = SumW'(sq[0]) + SumW'(sq[1]) + SumW'(sq[2]);
        dot  = SumW'(pr[0]) + SumW'(pr[1]) + SumW'(pr[2]);
        // squared threshold in place of a square root
        lim  = $signed(SumW'({1'b0, 32'(cfg.swing) * 32'(cfg.swing)}));
        flag = (len2 > lim) && ctrl.have_psd && (dot < 0);

        ring_base = ctrl.clr ? '0 : ring_reg;
        fill_base = ctrl.clr ? '0 : fill_reg;
        ring_next = ring_base;
        fill_next = fill_base;
        if (ctrl.shift)
        begin
            ring_next = {ring_base[HISTORY_DEPTH-2:0], flag};
            if (fill_base < FillW'(HISTORY_DEPTH))
                fill_next = fill_base + FillW'(1);
        end
        ones = CmpW'($countones(ring_next));

        if (ctrl.fresh)
            mode_next = MODE_STEREO;
        else if (fill_next == FillW'(HISTORY_DEPTH))
            mode_next = (ones >= CmpW'(cfg.vote_thr)) ? MODE_ALTERNATING : MODE_MONO;
        else
            mode_next = MODE_UNKNOWN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg <= '0;
            fill_reg <= '0;
        end
        else if (step_en)
        begin
            ring_reg <= ring_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            mode_reg    <= mode_next;
            count_reg   <= count;
            is_mono_reg <= (mode_next == MODE_MONO) && (cfg.method == METHOD_MONO)
                           && cfg.shared;
        end
    end

    assign mode         = mode_reg;
    assign sample_count = count_reg;
    assign is_mono      = is_mono_reg;

endmodule

// File: src/view_topology_detector.sv
// ----------------------------------------------------------------------------
// view_topology_detector: stereo, alternating-eye or mono view detection
// classifies the render topology from the stream of view callbacks
// ----------------------------------------------------------------------------
// Each request carries one view callback (eye slot and position) and yields
// exactly one result: mode, running sample count and the is_mono flag. The
// block takes one request every cycle while in_stall is low. It has three
// registers: an input register, a difference stage that updates the per-slot
// history and registers the second difference, and a vote stage that runs the
// squares and dot product in parallel, updates the vote ring and registers
// the result; out_valid rises once a request has passed through all three in
// that order. Each piece of request-to-request state closes its loop within
// one of those stages, which is what holds the rate at one per cycle. Stalls
// on the result side back up only as far as needed; empty stages keep filling.
// Configuration writes are always ready and should be made while no request
// is in flight.
// ----------------------------------------------------------------------------
module view_topology_detector
    import vtd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            eye_index,
    input  logic signed [POSITION_BITS-1:0] pos_x,
    input  logic signed [POSITION_BITS-1:0] pos_y,
    input  logic signed [POSITION_BITS-1:0] pos_z,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      mode,
    output logic [COUNT_W-1:0]              sample_count,
    output logic                            is_mono,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [CFG_INDEX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]           cfg_data
);

    // configuration registers
    logic [15:0]       cfg_swing_reg;
    logic [7:0]        cfg_stale_reg;
    logic [3:0]        cfg_vote_reg;
    logic signed [2:0] cfg_method_reg;
    logic              cfg_shared_reg;

    // pipeline occupancy
    logic s0_valid_reg;
    logic s1_valid_reg;
    logic out_valid_reg;

    // input register
    logic                            eye_reg;
    logic signed [POSITION_BITS-1:0] pos_reg [3];

    logic en_out;
    logic en_s1;
    logic en_s0;
    logic load_s1;
    logic step;

    vtd_cfg_t                        vote_cfg;
    vtd_ctrl_t                       ctrl;
    logic signed [POSITION_BITS+1:0] accel [3];
    logic signed [POSITION_BITS+1:0] prev_accel [3];
    logic [COUNT_W-1:0]              count;

    // a stage moves when it is empty or the stage after it moves
    assign en_out   = !out_valid_reg || !out_stall;
    assign en_s1    = !s1_valid_reg || en_out;
    assign en_s0    = !s0_valid_reg || en_s1;
    assign load_s1  = s0_valid_reg && en_s1;
    assign step     = s1_valid_reg && en_out;
    assign in_stall = !en_s0;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    // register decoder, writes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_swing_reg  <= SWING_RESET;
            cfg_stale_reg  <= STALE_RESET;
            cfg_vote_reg   <= VOTE_RESET;
            cfg_method_reg <= METHOD_RESET;
            cfg_shared_reg <= SHARED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SWING:  cfg_swing_reg  <= cfg_data[15:0];
                REG_STALE:  cfg_stale_reg  <= cfg_data[7:0];
                REG_VOTE:   cfg_vote_reg   <= cfg_data[3:0];
                REG_METHOD: cfg_method_reg <= $signed(cfg_data[2:0]);
                REG_SHARED: cfg_shared_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_s0)
                s0_valid_reg <= in_valid;
            if (en_s1)
                s1_valid_reg <= s0_valid_reg;
            if (en_out)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (in_valid && en_s0)
        begin
            eye_reg    <= eye_index;
            pos_reg[0] <= pos_x;
            pos_reg[1] <= pos_y;
            pos_reg[2] <= pos_z;
        end
    end

    assign vote_cfg.swing    = cfg_swing_reg;
    assign vote_cfg.vote_thr = cfg_vote_reg;
    assign vote_cfg.method   = cfg_method_reg;
    assign vote_cfg.shared   = cfg_shared_reg;

    // slot history and second difference
    vtd_diff #(
        .POSITION_BITS (POSITION_BITS)
    ) u_diff (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_en     (load_s1),
        .stale_limit (cfg_stale_reg),
        .eye_index   (eye_reg),
        .pos         (pos_reg),
        .accel       (accel),
        .prev_accel  (prev_accel),
        .ctrl        (ctrl),
        .count       (count)
    );

    // swing test, vote ring and result register
    vtd_vote #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) u_vote (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (step),
        .cfg          (vote_cfg),
        .ctrl         (ctrl),
        .accel        (accel),
        .prev_accel   (prev_accel),
        .count        (count),
        .mode         (mode),
        .sample_count (sample_count),
        .is_mono      (is_mono)
    );

    // is_mono only ever accompanies a mono verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_mono |-> mode == MODE_MONO)
        else $error("is_mono without mono mode");

    // an accepted request lands in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> s0_valid_reg)
        else $error("accepted request lost at input register");

    // a request leaving the vote stage shows up as a result
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && en_out |=> out_valid_reg)
        else $error("vote stage result not presented");

    // nothing is presented while the pipeline held no request
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg && en_out |=> !out_valid_reg)
        else $error("result invented from empty stage");

endmodule
